>>> rtl/mfps_pkg.sv
package mfps_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 16;

  localparam int WIDTH_BITS = 11;
  localparam int WIDTH_RST  = 1024;

  localparam int SUM_BITS = 28;
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  localparam int RESULT_BYTES = (SUM_BITS + 7) / 8;
  localparam int RESULT_DATA_BITS = RESULT_BYTES * 8;

  typedef logic signed [SUM_BITS-1:0] sum_t;

  typedef struct packed {
    sum_t best_sum;
    logic short_row;
  } result_t;

endpackage

>>> rtl/max_falling_path_sum.sv
// Maximum falling path sum over a grid streamed one cell per item in
// row-major order, row width set through the cfg port (0 acts as 1, values
// above MAX_COLS act as MAX_COLS; a write abandons the grid in progress).
// The previous row's best sums live in a chain of MAX_COLS cells that shifts
// by one on every accepted item, so one cell is taken every clock cycle while
// s_tready is high; the cell's new best (its value plus the largest of the
// three sums above, saturated to 28 bits) is computed in the same cycle from
// head, right and left_prev. An item with tlast set produces one result: the
// largest best of the final row and a flag for a row that ended early.
// s_tready drops only while two results wait unread on the master side.
module max_falling_path_sum #(
  parameter int MAX_COLS   = mfps_pkg::MAX_COLS_DEF,
  parameter int VALUE_BITS = mfps_pkg::VALUE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration: row_width
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mfps_pkg::WIDTH_BITS-1:0]         cfg_data,
  // input items
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]         s_tdata,   // cell_value
  input  logic                                    s_tlast,   // last_cell
  // result items
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [mfps_pkg::RESULT_DATA_BITS-1:0]   m_tdata,   // best_sum
  output logic                                    m_tuser    // short_row
);

  localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int EXT = ((VALUE_BITS > mfps_pkg::SUM_BITS) ? VALUE_BITS
                                                         : mfps_pkg::SUM_BITS) + 1;
  localparam int TAIL_RST = ((mfps_pkg::WIDTH_RST > MAX_COLS) ? MAX_COLS
                                                               : mfps_pkg::WIDTH_RST) - 1;
  localparam logic signed [EXT-1:0] EXT_MAX =
    {{(EXT-mfps_pkg::SUM_BITS){1'b0}}, mfps_pkg::SUM_MAX};
  localparam logic signed [EXT-1:0] EXT_MIN =
    {{(EXT-mfps_pkg::SUM_BITS){1'b1}}, mfps_pkg::SUM_MIN};

  logic [COL_BITS-1:0]    tail_idx;
  logic [COL_BITS-1:0]    col;
  logic                   first_row;
  mfps_pkg::sum_t         left_prev;
  mfps_pkg::sum_t         row_best;
  logic [COL_BITS-1:0]    tail_idx_next;

  mfps_pkg::sum_t         chain [MAX_COLS];
  mfps_pkg::sum_t         chain_in [MAX_COLS];
  mfps_pkg::sum_t         head;
  mfps_pkg::sum_t         right;

  logic                   accept;
  logic                   at_tail;
  logic signed [VALUE_BITS-1:0] value;
  mfps_pkg::sum_t         above_best;
  logic signed [EXT-1:0]  total;
  mfps_pkg::sum_t         fresh;
  mfps_pkg::sum_t         row_best_next;
  mfps_pkg::result_t      result;
  mfps_pkg::result_t      out_data;
  logic                   q_full;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign value     = s_tdata[VALUE_BITS-1:0];
  assign at_tail   = (col == tail_idx);

  // effective row width minus one
  always_comb begin
    if (cfg_data == '0) begin
      tail_idx_next = '0;
    end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
      tail_idx_next = COL_BITS'(MAX_COLS - 1);
    end else begin
      tail_idx_next = COL_BITS'(cfg_data - mfps_pkg::WIDTH_BITS'(1));
    end
  end

  // row buffer chain
  genvar gi;
  generate
    for (gi = 0; gi < MAX_COLS; gi++) begin : g_cell
      if (gi == MAX_COLS - 1) begin : g_end
        assign chain_in[gi] = fresh;
      end else begin : g_mid
        assign chain_in[gi] = chain[gi+1];
      end
      mfps_cell #(
        .IDX      (gi),
        .COL_BITS (COL_BITS)
      ) u_cell (
        .clk      (clk),
        .shift    (accept),
        .tail_idx (tail_idx),
        .fresh    (fresh),
        .upstream (chain_in[gi]),
        .sum      (chain[gi])
      );
    end
    if (MAX_COLS > 1) begin : g_right
      assign right = chain[1];
    end else begin : g_right_none
      assign right = chain[0];
    end
  endgenerate

  assign head = chain[0];

  // best of the three sums above
  always_comb begin
    above_best = head;
    if (col != '0 && left_prev > above_best) begin
      above_best = left_prev;
    end
    if (!at_tail && right > above_best) begin
      above_best = right;
    end
  end

  always_comb begin
    if (first_row) begin
      total = EXT'(value);
    end else begin
      total = EXT'(value) + EXT'(above_best);
    end
    if (total > EXT_MAX) begin
      fresh = mfps_pkg::SUM_MAX;
    end else if (total < EXT_MIN) begin
      fresh = mfps_pkg::SUM_MIN;
    end else begin
      fresh = total[mfps_pkg::SUM_BITS-1:0];
    end
    row_best_next = (col == '0 || fresh > row_best) ? fresh : row_best;
  end

  assign result.best_sum  = row_best_next;
  assign result.short_row = !at_tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_idx  <= COL_BITS'(TAIL_RST);
      col       <= '0;
      first_row <= 1'b1;
      left_prev <= '0;
      row_best  <= mfps_pkg::SUM_MIN;
    end else if (cfg_valid) begin
      tail_idx  <= tail_idx_next;
      col       <= '0;
      first_row <= 1'b1;
      left_prev <= '0;
      row_best  <= mfps_pkg::SUM_MIN;
    end else if (accept) begin
      if (s_tlast) begin
        // restart for the next grid
        col       <= '0;
        first_row <= 1'b1;
        left_prev <= '0;
        row_best  <= mfps_pkg::SUM_MIN;
      end else begin
        left_prev <= head;
        row_best  <= row_best_next;
        if (at_tail) begin
          col       <= '0;
          first_row <= 1'b0;
        end else begin
          col <= col + COL_BITS'(1);
        end
      end
    end
  end

  mfps_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && s_tlast),
    .push_data  (result),
    .pop_ready  (m_tready),
    .head_valid (m_tvalid),
    .head_data  (out_data),
    .full       (q_full)
  );

  assign m_tdata = {{(mfps_pkg::RESULT_DATA_BITS-mfps_pkg::SUM_BITS){1'b0}},
                    out_data.best_sum};
  assign m_tuser = out_data.short_row;

endmodule

>>> rtl/mfps_cell.sv
// One column of the row buffer: load the fresh sum when this cell is the
// tail of the active row, otherwise take the neighbor's sum on every shift.
module mfps_cell #(
  parameter int IDX      = 0,
  parameter int COL_BITS = 10
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic [COL_BITS-1:0]  tail_idx,
  input  mfps_pkg::sum_t       fresh,
  input  mfps_pkg::sum_t       upstream,
  output mfps_pkg::sum_t       sum
);

  logic is_tail;

  assign is_tail = (tail_idx == COL_BITS'(IDX));

  always_ff @(posedge clk) begin
    if (shift) begin
      sum <= is_tail ? fresh : upstream;
    end
  end

endmodule

>>> rtl/mfps_outq.sv
// Two-entry result queue: head drives the output, second entry catches a
// result that arrives while the head is stalled.
module mfps_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mfps_pkg::result_t push_data,
  input  logic              pop_ready,
  output logic              head_valid,
  output mfps_pkg::result_t head_data,
  output logic              full
);

  logic              spare_valid;
  mfps_pkg::result_t spare_data;
  logic              pop;

  assign pop  = head_valid && pop_ready;
  assign full = spare_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (spare_valid) begin
          head_data   <= spare_data;
          spare_valid <= push;
          if (push) begin
            spare_data <= push_data;
          end
        end else if (push) begin
          head_data <= push_data;
        end else begin
          head_valid <= 1'b0;
        end
      end else if (push) begin
        if (!head_valid) begin
          head_data  <= push_data;
          head_valid <= 1'b1;
        end else begin
          spare_data  <= push_data;
          spare_valid <= 1'b1;
        end
      end
    end
  end

endmodule
